// ===== rtl/tes_pkg.sv =====
// package: shared types, codes and defaults for the timer expiry scheduler
`timescale 1ns / 1ps
`default_nettype none
package tes_pkg;
	localparam int TIMER_SLOTS_DEF = 16;
	localparam int MAX_RESULTS     = 16;
	localparam int TIME_W          = 48;
	localparam int ID_W            = 32;
	localparam int OWNER_W         = 16;
	localparam int ARG_W           = 32;
	localparam int PERIOD_W        = 32;
	localparam int NFIRE_W         = $clog2(MAX_RESULTS + 1);

	localparam logic [1:0] FUNC_TICK       = 2'd0;
	localparam logic [1:0] FUNC_ADD        = 2'd1;
	localparam logic [1:0] FUNC_CANCEL     = 2'd2;
	localparam logic [1:0] FUNC_CANCEL_ALL = 2'd3;

	localparam logic [1:0] KIND_ADD_ACK    = 2'd0;
	localparam logic [1:0] KIND_CANCEL_ACK = 2'd1;
	localparam logic [1:0] KIND_EXPIRY     = 2'd2;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_FULL      = 2'd1;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic [TIME_W-1:0]   due;
		logic [PERIOD_W-1:0] period;
		logic [OWNER_W-1:0]  owner;
		logic [ARG_W-1:0]    arg;
		logic [ID_W-1:0]     ident;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);
endpackage
`default_nettype wire

// ===== rtl/timer_expiry_scheduler_unit.sv =====
// top level: timer slot store with a sequencer that scans the slots one per cycle
// add: ST_ADD allocates a free slot, if any, and loads the result once the output register is free
// cancel and cancel-all: one slot scan, then the result once the output register is free
// tick: one scan per fired timer, plus a final scan unless MAX_RESULTS timers have fired
// one item at a time; in_ready is high only while idle
// async reset clears all slot valid bits, the clock to 0 and the id counter to 1
`timescale 1ns / 1ps
`default_nettype none
module timer_expiry_scheduler_unit #(
	parameter int TIMER_SLOTS = tes_pkg::TIMER_SLOTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  func,
	input  wire logic [15:0] owner_id,
	input  wire logic [31:0] timer_id,
	input  wire logic [31:0] initial_delay_ms,
	input  wire logic [31:0] interval_ms,
	input  wire logic signed [31:0] user_arg,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic [1:0]       status,
	output logic [31:0]      fired_id,
	output logic [15:0]      fired_owner,
	output logic signed [31:0] fired_arg,
	output logic             last
);
	localparam int IW = $clog2(TIMER_SLOTS);
	localparam int AW = $clog2(TIMER_SLOTS + 1);
	localparam int CW = $clog2(TIMER_SLOTS + 1);

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ADD   = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_FIRE  = 3'd3;
	localparam logic [2:0] ST_FLUSH = 3'd4;

	logic [2:0] state_q;

	// latched command
	logic [1:0]                     func_q;
	logic [tes_pkg::OWNER_W-1:0]    own_q;
	logic [tes_pkg::ID_W-1:0]       tid_q;
	logic [31:0]                    delay_q;
	logic [tes_pkg::PERIOD_W-1:0]   period_q;
	logic [tes_pkg::ARG_W-1:0]      arg_q;

	// slot state in flops
	logic [TIMER_SLOTS-1:0]         valid_q;
	logic [TIMER_SLOTS-1:0]         done_q;
	logic [tes_pkg::TIME_W-1:0]     now_q;
	logic [tes_pkg::ID_W-1:0]       next_id_q;

	// scan pipeline
	logic [AW-1:0]                  addr_q;
	logic                           rd_vld_s1;
	logic [IW-1:0]                  rd_idx_s1;
	tes_pkg::entry_t                ent;

	// scan results
	logic                           best_vld_q;
	tes_pkg::entry_t                best_q;
	logic [IW-1:0]                  best_idx_q;
	logic                           hit_q;
	logic                           ok_q;
	logic [CW-1:0]                  cnt_q;
	logic [tes_pkg::NFIRE_W-1:0]    nfire_q;

	// one fired timer held back until we know whether it is the last
	logic                           hold_vld_q;
	tes_pkg::entry_t                hold_q;

	// output register
	logic                           out_valid_q;

	logic                           out_free;
	logic                           out_load;
	logic                           issue;
	logic                           scan_end;
	logic                           cur_v;
	logic                           cur_d;
	logic                           tk_better;
	logic                           cx_hit;
	logic                           cx_ok;
	logic                           ca_hit;
	logic                           fire_go;
	logic                           free_found;
	logic [IW-1:0]                  free_idx;
	logic [tes_pkg::NFIRE_W-1:0]    nfire_nx;
	logic [tes_pkg::ID_W-1:0]       next_id_inc;

	logic                           ram_we;
	logic [IW-1:0]                  ram_waddr;
	tes_pkg::entry_t                ram_wdata;
	tes_pkg::entry_t                add_ent;
	tes_pkg::entry_t                rearm_ent;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// scan control: one read issued per cycle, its data evaluated in the cycle after
	assign issue    = (state_q == ST_SCAN) && (addr_q != AW'(TIMER_SLOTS));
	assign scan_end = (state_q == ST_SCAN) && !issue && !rd_vld_s1;

	assign cur_v = valid_q[rd_idx_s1];
	assign cur_d = done_q[rd_idx_s1];

	// earliest due time, then lowest id; strict compare keeps lowest slot on ties
	assign tk_better = rd_vld_s1 && (func_q == tes_pkg::FUNC_TICK) && cur_v && !cur_d
		&& (ent.due <= now_q)
		&& (!best_vld_q || (ent.due < best_q.due)
			|| ((ent.due == best_q.due) && (ent.ident < best_q.ident)));

	// first valid slot with matching id decides the cancel
	assign cx_hit = rd_vld_s1 && (func_q == tes_pkg::FUNC_CANCEL) && cur_v && !hit_q
		&& (tid_q != '0) && (ent.ident == tid_q);
	assign cx_ok  = cx_hit && ((own_q == '0) || (ent.owner == own_q));

	assign ca_hit = rd_vld_s1 && (func_q == tes_pkg::FUNC_CANCEL_ALL) && cur_v
		&& (ent.owner == own_q);

	// a fire step waits only if it has an earlier timer to hand out
	assign fire_go  = (state_q == ST_FIRE) && (!hold_vld_q || out_free);
	assign nfire_nx = nfire_q + 1'b1;

	assign next_id_inc = next_id_q + 1'b1;

	// the output register takes a new result in exactly these cases
	assign out_load = ((state_q == ST_ADD) && out_free)
		|| (scan_end && (func_q != tes_pkg::FUNC_TICK) && out_free)
		|| (fire_go && hold_vld_q)
		|| ((state_q == ST_FLUSH) && out_free);

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
		end
	end

	always_comb begin
		add_ent.due    = now_q + tes_pkg::TIME_W'(delay_q);
		add_ent.period = period_q;
		add_ent.owner  = own_q;
		add_ent.arg    = arg_q;
		add_ent.ident  = next_id_q;
		rearm_ent      = best_q;
		rearm_ent.due  = now_q + tes_pkg::TIME_W'(best_q.period);
	end

	// single ram write port: allocation or periodic re-arm
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = best_idx_q;
		ram_wdata = rearm_ent;
		if (state_q == ST_ADD) begin
			ram_we    = out_free && free_found;
			ram_waddr = free_idx;
			ram_wdata = add_ent;
		end else if (fire_go && (best_q.period != '0)) begin
			ram_we = 1'b1;
		end
	end

	tes_ram #(
		.WIDTH(tes_pkg::ENTRY_W),
		.DEPTH(TIMER_SLOTS)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(addr_q[IW-1:0]),
		.rdata(ent)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			done_q      <= '0;
			now_q       <= '0;
			next_id_q   <= tes_pkg::ID_W'(1);
			addr_q      <= '0;
			rd_vld_s1   <= 1'b0;
			best_vld_q  <= 1'b0;
			hit_q       <= 1'b0;
			ok_q        <= 1'b0;
			cnt_q       <= '0;
			nfire_q     <= '0;
			hold_vld_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (func == tes_pkg::FUNC_ADD) begin
							state_q <= ST_ADD;
						end else begin
							state_q    <= ST_SCAN;
							addr_q     <= '0;
							best_vld_q <= 1'b0;
							hit_q      <= 1'b0;
							ok_q       <= 1'b0;
							cnt_q      <= '0;
							if (func == tes_pkg::FUNC_TICK) begin
								now_q      <= now_q + 1'b1;
								done_q     <= '0;
								nfire_q    <= '0;
								hold_vld_q <= 1'b0;
							end
						end
					end
				end
				ST_ADD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (free_found) begin
							valid_q[free_idx] <= 1'b1;
							next_id_q <= (next_id_inc == '0) ? tes_pkg::ID_W'(1) : next_id_inc;
						end
					end
				end
				ST_SCAN: begin
					if (issue) begin
						addr_q <= addr_q + 1'b1;
					end
					rd_vld_s1 <= issue;
					if (tk_better) begin
						best_vld_q <= 1'b1;
					end
					if (cx_hit) begin
						hit_q <= 1'b1;
					end
					if (cx_ok) begin
						valid_q[rd_idx_s1] <= 1'b0;
						ok_q <= 1'b1;
					end
					if (ca_hit) begin
						valid_q[rd_idx_s1] <= 1'b0;
						cnt_q <= cnt_q + 1'b1;
					end
					if (scan_end) begin
						if (func_q == tes_pkg::FUNC_TICK) begin
							if (best_vld_q) begin
								state_q <= ST_FIRE;
							end else if (hold_vld_q) begin
								state_q <= ST_FLUSH;
							end else begin
								state_q <= ST_IDLE;
							end
						end else if (out_free) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_FIRE: begin
					if (fire_go) begin
						hold_vld_q         <= 1'b1;
						done_q[best_idx_q] <= 1'b1;
						if (best_q.period == '0) begin
							valid_q[best_idx_q] <= 1'b0;
						end
						nfire_q <= nfire_nx;
						if (nfire_nx == tes_pkg::NFIRE_W'(tes_pkg::MAX_RESULTS)) begin
							state_q <= ST_FLUSH;
						end else begin
							state_q    <= ST_SCAN;
							addr_q     <= '0;
							best_vld_q <= 1'b0;
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						hold_vld_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_q   <= func;
			own_q    <= owner_id;
			tid_q    <= timer_id;
			delay_q  <= initial_delay_ms;
			period_q <= interval_ms;
			arg_q    <= user_arg;
		end
		rd_idx_s1 <= addr_q[IW-1:0];
		if (tk_better) begin
			best_q     <= ent;
			best_idx_q <= rd_idx_s1;
		end
		if ((state_q == ST_ADD) && out_free) begin
			kind        <= tes_pkg::KIND_ADD_ACK;
			status      <= free_found ? tes_pkg::STATUS_OK : tes_pkg::STATUS_FULL;
			fired_id    <= free_found ? next_id_q : '0;
			fired_owner <= '0;
			fired_arg   <= '0;
			last        <= 1'b1;
		end
		if (scan_end && (func_q != tes_pkg::FUNC_TICK) && out_free) begin
			kind        <= tes_pkg::KIND_CANCEL_ACK;
			fired_owner <= '0;
			fired_arg   <= '0;
			last        <= 1'b1;
			if (func_q == tes_pkg::FUNC_CANCEL) begin
				status   <= ok_q ? tes_pkg::STATUS_OK : tes_pkg::STATUS_NOT_FOUND;
				fired_id <= tid_q;
			end else begin
				status   <= (cnt_q != '0) ? tes_pkg::STATUS_OK : tes_pkg::STATUS_NOT_FOUND;
				fired_id <= tes_pkg::ID_W'(cnt_q);
			end
		end
		if (fire_go) begin
			hold_q <= best_q;
			if (hold_vld_q) begin
				kind        <= tes_pkg::KIND_EXPIRY;
				status      <= tes_pkg::STATUS_OK;
				fired_id    <= hold_q.ident;
				fired_owner <= hold_q.owner;
				fired_arg   <= hold_q.arg;
				last        <= 1'b0;
			end
		end
		if ((state_q == ST_FLUSH) && out_free) begin
			kind        <= tes_pkg::KIND_EXPIRY;
			status      <= tes_pkg::STATUS_OK;
			fired_id    <= hold_q.ident;
			fired_owner <= hold_q.owner;
			fired_arg   <= hold_q.arg;
			last        <= 1'b1;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/tes_ram.sv =====
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module tes_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire
